// ----- rtl/ksq_pkg.sv -----
// Shared types and constants for the key state and event queue core.
// No dependencies; imported by every module of the block.
package ksq_pkg;

  localparam int KEY_W           = 8;
  localparam int CHAR_W          = 8;
  localparam int EVENT_W         = KEY_W + 1;
  localparam int NUM_KEYS        = 1 << KEY_W;
  localparam int QUEUE_DEPTH_DEF = 16;

  typedef enum logic [3:0] {
    ACT_PRESS       = 4'd0,
    ACT_RELEASE     = 4'd1,
    ACT_CHAR        = 4'd2,
    ACT_READ_EVENT  = 4'd3,
    ACT_READ_CHAR   = 4'd4,
    ACT_QUERY       = 4'd5,
    ACT_FLUSH_EVENT = 4'd6,
    ACT_FLUSH_CHAR  = 4'd7,
    ACT_FLUSH_BOTH  = 4'd8,
    ACT_CLEAR_MAP   = 4'd9
  } ksq_action_e;

  typedef struct packed {
    logic push;
    logic pop;
    logic flush;
  } ksq_ring_ctl_t;

  typedef struct packed {
    logic set;
    logic clr;
    logic clear_all;
  } ksq_map_ctl_t;

endpackage

// ----- rtl/ksq_ring.sv -----
// Bounded ring queue; a push into a full queue overwrites the oldest word.
// Depends on ksq_pkg for the control struct.
module ksq_ring import ksq_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF,
  parameter int WIDTH = CHAR_W
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ksq_ring_ctl_t        ctl_i,
  input  logic [WIDTH-1:0]     wdata_i,
  output logic [WIDTH-1:0]     rdata_o,
  output logic                 pop_ok_o,
  output logic                 empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] head_q, head_d, head_inc, wr_idx;
  logic [CNT_W-1:0] count_q, count_d;
  logic [SUM_W-1:0] tail_sum;
  logic             full, pop_ok;

  assign full     = (count_q == CNT_W'(DEPTH));
  assign pop_ok   = ctl_i.pop && (count_q != '0);
  assign head_inc = (head_q == PTR_W'(DEPTH - 1)) ? '0 : head_q + PTR_W'(1);

  always_comb begin
    tail_sum = SUM_W'(head_q) + SUM_W'(count_q);
    if (tail_sum >= SUM_W'(DEPTH)) begin
      tail_sum = tail_sum - SUM_W'(DEPTH);
    end
    wr_idx = full ? head_q : tail_sum[PTR_W-1:0];
  end

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    if (ctl_i.flush) begin
      head_d  = '0;
      count_d = '0;
    end else if (ctl_i.push) begin
      if (full) begin
        head_d = head_inc;
      end else begin
        count_d = count_q + CNT_W'(1);
      end
    end else if (pop_ok) begin
      head_d  = head_inc;
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.push && !ctl_i.flush) begin
      mem_q[wr_idx] <= wdata_i;
    end
  end

  assign rdata_o  = pop_ok ? mem_q[head_q] : '0;
  assign pop_ok_o = pop_ok;
  assign empty_o  = (count_d == '0);

endmodule

// ----- rtl/ksq_keymap.sv -----
// Key-down bitmap: one flop per key code, cleared at reset or on request.
// Depends on ksq_pkg for widths and the control struct.
module ksq_keymap import ksq_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ksq_map_ctl_t     ctl_i,
  input  logic [KEY_W-1:0] key_i,
  output logic             key_down_o
);

  logic [NUM_KEYS-1:0] map_q, map_d;

  always_comb begin
    map_d = map_q;
    if (ctl_i.clear_all) begin
      map_d = '0;
    end else if (ctl_i.set) begin
      map_d[key_i] = 1'b1;
    end else if (ctl_i.clr) begin
      map_d[key_i] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_q <= '0;
    end else begin
      map_q <= map_d;
    end
  end

  // state after this step
  assign key_down_o = map_d[key_i];

endmodule

// ----- rtl/key_state_and_event_queue_core.sv -----
// Top level of the key state and event queue core.
// Depends on ksq_pkg, ksq_ring and ksq_keymap.
//
// Usage:
//   Input channel: in_valid_i / in_stall_o carry one command word
//   (action_i, key_code_i, char_code_i). Output channel: out_valid_o /
//   out_stall_i carry one result word per command. A word moves on a
//   rising edge where valid is high and stall is low.
//   Every command yields exactly one result word, in command order.
//   The result passes the input register, then the result register,
//   before it is presented. Throughput: one command per cycle while
//   the receiver does not stall; the queues and key map update in the
//   single pass between the two registers.
//   When the receiver stalls, the result register holds its word; an
//   empty input register still takes one more command. While the input
//   register holds a command, in_stall_o is high until the result is taken.
//   Reset (rst_ni low, async) empties both queues, releases every key and
//   clears the valid bits of both pipeline registers. Queue storage is not
//   cleared; entries are only read after being written.
module key_state_and_event_queue_core import ksq_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [3:0]        action_i,
  input  logic [KEY_W-1:0]  key_code_i,
  input  logic [CHAR_W-1:0] char_code_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              event_valid_o,
  output logic              event_is_press_o,
  output logic [KEY_W-1:0]  event_key_o,
  output logic [CHAR_W-1:0] char_value_o,
  output logic              key_down_o,
  output logic              events_empty_o,
  output logic              chars_empty_o
);

  logic              in_vld_q;
  ksq_action_e       act_q;
  logic [KEY_W-1:0]  key_q;
  logic [CHAR_W-1:0] chr_q;

  logic out_ready, fire, in_take;

  ksq_ring_ctl_t ev_ctl, ch_ctl;
  ksq_map_ctl_t  map_ctl;

  logic [EVENT_W-1:0] ev_rdata;
  logic [CHAR_W-1:0]  ch_rdata;
  logic               ev_pop_ok, ch_pop_ok, ev_empty, ch_empty, key_down;

  logic              out_vld_q;
  logic              ev_vld_q, ev_press_q, key_down_q, ev_empty_q, ch_empty_q;
  logic [KEY_W-1:0]  ev_key_q;
  logic [CHAR_W-1:0] ch_val_q;

  assign out_ready  = !out_vld_q || !out_stall_i;
  assign fire       = in_vld_q && out_ready;
  assign in_stall_o = in_vld_q && !out_ready;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (fire) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      act_q <= ksq_action_e'(action_i);
      key_q <= key_code_i;
      chr_q <= char_code_i;
    end
  end

  // command decode
  always_comb begin
    ev_ctl  = '0;
    ch_ctl  = '0;
    map_ctl = '0;
    if (fire) begin
      case (act_q)
        ACT_PRESS: begin
          map_ctl.set = 1'b1;
          ev_ctl.push = 1'b1;
        end
        ACT_RELEASE: begin
          map_ctl.clr = 1'b1;
          ev_ctl.push = 1'b1;
        end
        ACT_CHAR:        ch_ctl.push = 1'b1;
        ACT_READ_EVENT:  ev_ctl.pop  = 1'b1;
        ACT_READ_CHAR:   ch_ctl.pop  = 1'b1;
        ACT_FLUSH_EVENT: ev_ctl.flush = 1'b1;
        ACT_FLUSH_CHAR:  ch_ctl.flush = 1'b1;
        ACT_FLUSH_BOTH: begin
          ev_ctl.flush = 1'b1;
          ch_ctl.flush = 1'b1;
        end
        ACT_CLEAR_MAP:   map_ctl.clear_all = 1'b1;
        default: ;
      endcase
    end
  end

  ksq_ring #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (EVENT_W)
  ) u_ev_ring (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ev_ctl),
    .wdata_i  ({map_ctl.set, key_q}),
    .rdata_o  (ev_rdata),
    .pop_ok_o (ev_pop_ok),
    .empty_o  (ev_empty)
  );

  ksq_ring #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (CHAR_W)
  ) u_ch_ring (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ch_ctl),
    .wdata_i  (chr_q),
    .rdata_o  (ch_rdata),
    .pop_ok_o (ch_pop_ok),
    .empty_o  (ch_empty)
  );

  ksq_keymap u_keymap (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (map_ctl),
    .key_i      (key_q),
    .key_down_o (key_down)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (fire) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      ev_vld_q   <= ev_pop_ok;
      ev_press_q <= ev_rdata[EVENT_W-1];
      ev_key_q   <= ev_rdata[KEY_W-1:0];
      ch_val_q   <= ch_pop_ok ? ch_rdata : '0;
      key_down_q <= key_down;
      ev_empty_q <= ev_empty;
      ch_empty_q <= ch_empty;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign event_valid_o    = ev_vld_q;
  assign event_is_press_o = ev_press_q;
  assign event_key_o      = ev_key_q;
  assign char_value_o     = ch_val_q;
  assign key_down_o       = key_down_q;
  assign events_empty_o   = ev_empty_q;
  assign chars_empty_o    = ch_empty_q;

endmodule

// ----- rtl/ksq_checker.sv -----
// Port-level checks for key_state_and_event_queue_core, bound to the top.
// Depends on ksq_pkg for widths.
module ksq_checker import ksq_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic              event_valid_o,
  input logic              event_is_press_o,
  input logic [KEY_W-1:0]  event_key_o,
  input logic [CHAR_W-1:0] char_value_o
);

  // held result keeps its word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(event_key_o)
      && $stable(char_value_o))
    else $error("stalled result changed");

  // input only backs up behind a stalled full result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  // no real event means zeroed event fields
  a_event_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !event_valid_o |-> !event_is_press_o && event_key_o == '0)
    else $error("event fields set without a valid event");

  // one step pops at most one queue
  a_one_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_valid_o |-> char_value_o == '0)
    else $error("event and char popped in one step");

endmodule

bind key_state_and_event_queue_core ksq_checker u_ksq_checker (.*);
